// ===== src/pixel_color_space_converter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel color space converter
// Concurrent checks on the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH
`define PIXEL_COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication under the active-low reset
`define PCSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcsc: same-cycle check failed");

// Next-cycle implication under the active-low reset
`define PCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcsc: next-cycle check failed");

`else

`define PCSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/pcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsc_pkg
// Types, Q16 coefficients and the clamp helper of the color space converter.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    // Conversion selected by the mode register
    typedef enum logic [1:0] {
        MODE_RGB_TO_GRAY  = 2'd0,
        MODE_GRAY_TO_RGB  = 2'd1,
        MODE_RGB_TO_YCBCR = 2'd2,
        MODE_YCBCR_TO_RGB = 2'd3
    } mode_t;

    // Register indexes
    localparam logic REG_MODE = 1'b0;

    localparam int CHAN_W = 8;
    localparam int ACC_W  = 28;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Floor of sum/3 as (sum * 683) >> 11, exact for sums up to 765
    localparam int          SUM_W     = 10;
    localparam int          PROD3_W   = 20;
    localparam int          RECIP3_SH = 11;
    localparam logic [PROD3_W-1:0] RECIP3 = 20'd683;

    // RGB to YCbCr, Q16
    localparam acc_t K_Y_OFF  = 28'sd1048576;
    localparam acc_t K_Y_R    = 28'sd16829;
    localparam acc_t K_Y_G    = 28'sd33039;
    localparam acc_t K_Y_B    = 28'sd6416;
    localparam acc_t K_C_OFF  = 28'sd8388608;
    localparam acc_t K_CB_R   = 28'sd9714;
    localparam acc_t K_CB_G   = 28'sd19070;
    localparam acc_t K_CB_B   = 28'sd28784;
    localparam acc_t K_CR_R   = 28'sd28784;
    localparam acc_t K_CR_G   = 28'sd24103;
    localparam acc_t K_CR_B   = 28'sd4681;

    // YCbCr to RGB, Q16
    localparam acc_t K_R_CR   = 28'sd91881;
    localparam acc_t K_G_CB   = 28'sd22554;
    localparam acc_t K_G_CR   = 28'sd46802;
    localparam acc_t K_B_CB   = 28'sd116130;
    localparam acc_t K_CHROMA = 28'sd128;
    localparam acc_t Q16_MAX  = 28'sd16711680;

    // Clamp a Q16 sum to 0..255 and drop the fraction
    function automatic logic [CHAN_W-1:0] clamp_floor(input acc_t acc);
        logic [CHAN_W-1:0] res;
        if (acc < 0)
        begin
            res = '0;
        end
        else if (acc > Q16_MAX)
        begin
            res = '1;
        end
        else
        begin
            res = acc[23:16];
        end
        return res;
    endfunction

endpackage

// ===== src/pixel_color_space_converter_top.sv =====
// ----------------------------------------------------------------------------
// pixel_color_space_converter_top
// Per-pixel RGB / gray / BT.601 YCbCr conversion selected by a mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one pixel per word, s_tdata = {third, second, first}.
//   Master stream m_*: one converted pixel per word, same packing.
//   APB port: register 0 (byte address 0) holds conversion_mode in bits 1:0;
//   write it only while no pixel is in flight.
// Path: a pixel accepted on s_* is captured in the input register, then
//   converted into the result register and presented on m_*.
// Throughput: one pixel per clock while the result register can advance; the
//   whole conversion is one pass of constant multiplies and sums between the two registers.
// Reset: both stages empty, mode cleared to rgb-to-gray.
// Stall: while m_tready is low the result register holds its word and the
//   input register still takes one more pixel; s_tready drops only when
//   both stages are full.
// ----------------------------------------------------------------------------
`include "pixel_color_space_converter_top_defines.svh"

module pixel_color_space_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] chan_first, [15:8] chan_second, [23:16] chan_third
    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_first, [15:8] out_second, [23:16] out_third
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pcsc_pkg::*;

    mode_t             mode_reg;
    logic              in_valid_reg;
    logic [CHAN_W-1:0] in_first_reg;
    logic [CHAN_W-1:0] in_second_reg;
    logic [CHAN_W-1:0] in_third_reg;
    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_first_reg;
    logic [CHAN_W-1:0] out_second_reg;
    logic [CHAN_W-1:0] out_third_reg;

    logic [CHAN_W-1:0] out_first_next;
    logic [CHAN_W-1:0] out_second_next;
    logic [CHAN_W-1:0] out_third_next;
    logic              stage_adv;
    logic              cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
    assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RGB_TO_GRAY;
        end
        else if (cfg_wr)
        begin
            mode_reg <= mode_t'(pwdata[1:0]);
        end
    end

    // Pipeline control: advance into the result register when it is empty or its word is taken
    assign stage_adv = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || stage_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (stage_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_first_reg  <= s_tdata[7:0];
            in_second_reg <= s_tdata[15:8];
            in_third_reg  <= s_tdata[23:16];
        end
    end

    // Conversion datapath
    always_comb
    begin
        acc_t               a_s;
        acc_t               b_s;
        acc_t               c_s;
        acc_t               cb_s;
        acc_t               cr_s;
        acc_t               y_q;
        logic [SUM_W-1:0]   sum3;
        logic [PROD3_W-1:0] prod3;

        a_s   = acc_t'({20'd0, in_first_reg});
        b_s   = acc_t'({20'd0, in_second_reg});
        c_s   = acc_t'({20'd0, in_third_reg});
        cb_s  = b_s - K_CHROMA;
        cr_s  = c_s - K_CHROMA;
        y_q   = a_s <<< 16;
        sum3  = SUM_W'(in_first_reg) + SUM_W'(in_second_reg) + SUM_W'(in_third_reg);
        prod3 = PROD3_W'(sum3) * RECIP3;

        case (mode_reg)
            MODE_RGB_TO_GRAY:
            begin
                out_first_next  = prod3[RECIP3_SH +: CHAN_W];
                out_second_next = '0;
                out_third_next  = '0;
            end
            MODE_GRAY_TO_RGB:
            begin
                out_first_next  = in_first_reg;
                out_second_next = in_first_reg;
                out_third_next  = in_first_reg;
            end
            MODE_RGB_TO_YCBCR:
            begin
                out_first_next  = clamp_floor(K_Y_OFF + K_Y_R * a_s + K_Y_G * b_s
                                              + K_Y_B * c_s);
                out_second_next = clamp_floor(K_C_OFF - K_CB_R * a_s - K_CB_G * b_s
                                              + K_CB_B * c_s);
                out_third_next  = clamp_floor(K_C_OFF + K_CR_R * a_s - K_CR_G * b_s
                                              - K_CR_B * c_s);
            end
            default:
            begin
                out_first_next  = clamp_floor(y_q + K_R_CR * cr_s);
                out_second_next = clamp_floor(y_q - K_G_CB * cb_s - K_G_CR * cr_s);
                out_third_next  = clamp_floor(y_q + K_B_CB * cb_s);
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (stage_adv && in_valid_reg)
        begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_third_reg  <= out_third_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_third_reg, out_second_reg, out_first_reg};

    // Checks
    `PCSC_ASSERT_IMPLY(a_full_blocks, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `PCSC_ASSERT_NEXT(a_accept_fills, clk, rst_n, s_tvalid && s_tready, in_valid_reg)
    `PCSC_ASSERT_NEXT(a_moves_forward, clk, rst_n, in_valid_reg && !out_valid_reg, out_valid_reg)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color space converter testbench
// Streams pixels through the converter under each conversion mode and checks
// every converted word against hand-typed results or a Q16 fixed-point model.
// Directed pixels cover black, white, mid-gray and the clipping corners, then
// random pixels run under changing handshake pressure on both streams.
// ----------------------------------------------------------------------------
module testbench;

    import pcsc_pkg::*;

    // One pixel as it travels in tdata: first channel in the low byte
    typedef struct packed {
        logic [7:0] third;
        logic [7:0] second;
        logic [7:0] first;
    } pixel_t;

    // One directed step: mode to run under, pixel in, optional hand-typed result
    typedef struct {
        mode_t  mode;
        pixel_t px;
        bit     typed;
        pixel_t want;
    } vector_t;

    localparam int REG_SPARE = 1;               // unmapped index, writes ignored
    localparam logic [2:0] MODE_ADDR  = 3'(int'(REG_MODE) * 4);
    localparam logic [2:0] SPARE_ADDR = 3'(REG_SPARE * 4);

    localparam int DIRECTED_ROWS   = 21;
    localparam int ITEMS_PER_BLOCK = 112;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 60;
    localparam int REPORT_MAX      = 10;

    // Q16 coefficients of the BT.601 conversions
    localparam longint Q16_ONE  = 65536;
    localparam longint Q16_TOP  = 255 * 65536;
    localparam longint Y_R = 16829,  Y_G = 33039,  Y_B = 6416;
    localparam longint CB_R = 9714,  CB_G = 19070, CB_B = 28784;
    localparam longint CR_R = 28784, CR_G = 24103, CR_B = 4681;
    localparam longint R_CR = 91881, G_CB = 22554, G_CR = 46802, B_CB = 116130;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [7:0] chan_first, [15:8] chan_second, [23:16] chan_third
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] out_first, [15:8] out_second, [23:16] out_third
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mode_t   mode_shadow = MODE_RGB_TO_GRAY;
    pixel_t  pending_pixels [$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      stall_cycles = 0;
    vector_t steps [DIRECTED_ROWS];

    pixel_color_space_converter_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic pixel_t pix(input int f, input int s, input int t);
        pixel_t p;
        p.first  = 8'(f);
        p.second = 8'(s);
        p.third  = 8'(t);
        return p;
    endfunction

    // Clamp a Q16 sum to 0..255, then drop the fraction
    function automatic logic [7:0] clip_q16(input longint acc);
        logic [7:0] res;
        if (acc < 0)
        begin
            res = 8'd0;
        end
        else if (acc > Q16_TOP)
        begin
            res = 8'd255;
        end
        else
        begin
            res = 8'(acc >>> 16);
        end
        return res;
    endfunction

    // Converted pixel for one input pixel under the given mode
    function automatic pixel_t convert_pixel(input mode_t m, input pixel_t px);
        longint a, b, c, cb, cr, y;
        pixel_t res;
        a = longint'(px.first);
        b = longint'(px.second);
        c = longint'(px.third);
        cb = b - 128;
        cr = c - 128;
        y = a * Q16_ONE;
        case (m)
            MODE_RGB_TO_GRAY:
            begin
                res.first  = 8'((a + b + c) / 3);
                res.second = 8'd0;
                res.third  = 8'd0;
            end
            MODE_GRAY_TO_RGB:
            begin
                res.first  = px.first;
                res.second = px.first;
                res.third  = px.first;
            end
            MODE_RGB_TO_YCBCR:
            begin
                res.first  = clip_q16(16 * Q16_ONE + Y_R * a + Y_G * b + Y_B * c);
                res.second = clip_q16(128 * Q16_ONE - CB_R * a - CB_G * b + CB_B * c);
                res.third  = clip_q16(128 * Q16_ONE + CR_R * a - CR_G * b - CR_B * c);
            end
            default:
            begin
                res.first  = clip_q16(y + R_CR * cr);
                res.second = clip_q16(y - G_CB * cb - G_CR * cr);
                res.third  = clip_q16(y + B_CB * cb);
            end
        endcase
        return res;
    endfunction

    // Mirror a register write into the shadow copy of the configuration
    function automatic void shadow_register(input int index, input logic [31:0] value);
        if (index == int'(REG_MODE))
        begin
            mode_shadow = mode_t'(value[1:0]);
        end
    endfunction

    // Random channel byte, weighted toward the extremes and mid-scale
    function automatic logic [7:0] random_channel();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = 8'(128 + $urandom_range(0, 8) - 4);
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // One APB transfer: setup, access, then idle with psel low;
    // entered and left at a falling edge
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Stop the input stream and let every converted pixel drain out
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Select a mode with junk in the upper bits, poke the unmapped register, read back
    task automatic program_mode(input mode_t m);
        logic [31:0] wdata, rdata;
        drain_pixels();
        wdata = {30'($urandom), 2'(m)};
        apb_transfer(1'b1, MODE_ADDR, wdata, rdata);
        shadow_register(int'(REG_MODE), wdata);
        wdata = $urandom;
        apb_transfer(1'b1, SPARE_ADDR, wdata, rdata);
        shadow_register(REG_SPARE, wdata);
        apb_transfer(1'b0, MODE_ADDR, '0, rdata);
        if (rdata[1:0] !== mode_shadow)
        begin
            report_mismatch("mode readback", 32'(mode_shadow), 32'(rdata[1:0]));
        end
    endtask

    // Offer one pixel, after random idle cycles; returns at the falling edge after acceptance
    task automatic send_pixel(input pixel_t px, input pixel_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        pending_pixels.push_back(want);
        @(negedge clk);
    endtask

    // Receiver side: random back-pressure, or a long hold-off when asked for
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every converted word against the oldest pending expectation
    always @(posedge clk)
    begin
        pixel_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected word", '0, 32'(got));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.first !== want.first)
                begin
                    report_mismatch("out_first", 32'(want.first), 32'(got.first));
                end
                if (got.second !== want.second)
                begin
                    report_mismatch("out_second", 32'(want.second), 32'(got.second));
                end
                if (got.third !== want.third)
                begin
                    report_mismatch("out_third", 32'(want.third), 32'(got.third));
                end
            end
        end
    end

    // Watchdog: end the run when neither stream moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        pixel_t want, px;
        logic [31:0] rdata;

        steps = '{
            // rgb to gray from reset: mean floor, unused outputs zero
            '{MODE_RGB_TO_GRAY,  pix(0, 0, 0),         1'b1, pix(0, 0, 0)},
            '{MODE_RGB_TO_GRAY,  pix(255, 255, 255),   1'b1, pix(255, 0, 0)},
            '{MODE_RGB_TO_GRAY,  pix(255, 255, 254),   1'b1, pix(254, 0, 0)},
            '{MODE_RGB_TO_GRAY,  pix(1, 1, 0),         1'b1, pix(0, 0, 0)},
            '{MODE_RGB_TO_GRAY,  pix(8'hAA, 8'h55, 8'hF0), 1'b0, pix(0, 0, 0)},
            // gray to rgb: second and third inputs ignored
            '{MODE_GRAY_TO_RGB,  pix(0, 255, 255),     1'b1, pix(0, 0, 0)},
            '{MODE_GRAY_TO_RGB,  pix(255, 0, 0),       1'b1, pix(255, 255, 255)},
            '{MODE_GRAY_TO_RGB,  pix(77, 8'hA5, 8'h5A), 1'b1, pix(77, 77, 77)},
            // rgb to ycbcr: black and white land on studio range
            '{MODE_RGB_TO_YCBCR, pix(0, 0, 0),         1'b1, pix(16, 128, 128)},
            '{MODE_RGB_TO_YCBCR, pix(255, 255, 255),   1'b1, pix(235, 128, 128)},
            '{MODE_RGB_TO_YCBCR, pix(255, 0, 0),       1'b0, pix(0, 0, 0)},
            '{MODE_RGB_TO_YCBCR, pix(0, 255, 0),       1'b0, pix(0, 0, 0)},
            '{MODE_RGB_TO_YCBCR, pix(0, 0, 255),       1'b0, pix(0, 0, 0)},
            // ycbcr to rgb: neutral chroma, then clipping at both ends
            '{MODE_YCBCR_TO_RGB, pix(128, 128, 128),   1'b1, pix(128, 128, 128)},
            '{MODE_YCBCR_TO_RGB, pix(16, 128, 128),    1'b1, pix(16, 16, 16)},
            '{MODE_YCBCR_TO_RGB, pix(255, 255, 255),   1'b1, pix(255, 120, 255)},
            '{MODE_YCBCR_TO_RGB, pix(0, 0, 0),         1'b1, pix(0, 135, 0)},
            '{MODE_YCBCR_TO_RGB, pix(255, 0, 0),       1'b0, pix(0, 0, 0)},
            '{MODE_YCBCR_TO_RGB, pix(0, 255, 255),     1'b0, pix(0, 0, 0)},
            '{MODE_YCBCR_TO_RGB, pix(235, 16, 240),    1'b0, pix(0, 0, 0)},
            // back to gray through a register write
            '{MODE_RGB_TO_GRAY,  pix(8'h55, 8'hAA, 8'h0F), 1'b0, pix(0, 0, 0)}
        };

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Mode register must come out of reset as rgb to gray
        apb_transfer(1'b0, MODE_ADDR, '0, rdata);
        if (rdata[1:0] !== MODE_RGB_TO_GRAY)
        begin
            report_mismatch("mode after reset", 32'(MODE_RGB_TO_GRAY), 32'(rdata[1:0]));
        end

        // Directed pixels
        send_idle_pct = 20;
        recv_idle_pct = 20;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (steps[i].mode != mode_shadow)
            begin
                program_mode(steps[i].mode);
            end
            want = steps[i].typed ? steps[i].want : convert_pixel(mode_shadow, steps[i].px);
            send_pixel(steps[i].px, want);
        end

        // Random pixels: busy receiver, then busy sender, then full rate
        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 36 : (regime == 1) ? 78 : 0;
            recv_idle_pct = (regime == 0) ? 78 : (regime == 1) ? 36 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                program_mode(mode_t'((blk + regime) % 4));
                if (regime == 2 && blk == 0)
                begin
                    hold_req = 1'b1;
                end
                for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                begin
                    px.first  = random_channel();
                    px.second = random_channel();
                    px.third  = random_channel();
                    send_pixel(px, convert_pixel(mode_shadow, px));
                end
            end
        end

        // Let the pipeline empty, then watch for stray words before the verdict
        drain_pixels();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== pixel_color_space_converter_top.f =====
+incdir+src
src/pcsc_pkg.sv
src/pixel_color_space_converter_top.sv
tb/sv/testbench.sv
